// ----- rtl/crl2q_pkg.sv -----
// Shared types and constants for the LRU / 2Q cache directory.
// Used by the channel interfaces, the top level and the checker.
package crl2q_pkg;

  localparam int KEY_W      = 64;
  localparam int OP_W       = 2;
  localparam int FQ_W       = 2;
  localparam int OCC_W      = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;
  localparam int CNT_W      = 48;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD   = 2'd3;

  localparam logic [FQ_W-1:0] Q_NONE  = 2'd0;
  localparam logic [FQ_W-1:0] Q_AM    = 2'd1;
  localparam logic [FQ_W-1:0] Q_A1IN  = 2'd2;
  localparam logic [FQ_W-1:0] Q_A1OUT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A1IN_LIM  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1OUT_LIM = 4'd3;

  localparam logic [CFG_DATA_W-1:0] CAPACITY_RST  = 7'd64;
  localparam logic [CFG_DATA_W-1:0] A1IN_LIM_RST  = 7'd1;
  localparam logic [CFG_DATA_W-1:0] A1OUT_LIM_RST = 7'd32;

endpackage

// ----- rtl/crl2q_cmd_if.sv -----
// Command channel: operation and key, valid/ready.
// Depends on crl2q_pkg.
interface crl2q_cmd_if import crl2q_pkg::*;;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] operation;
  logic [KEY_W-1:0] key;
  modport source(output valid, operation, key, input ready);
  modport sink(input valid, operation, key, output ready);
endinterface

// ----- rtl/crl2q_rsp_if.sv -----
// Response channel: lookup result, eviction and occupancy, valid/ready.
// Depends on crl2q_pkg.
interface crl2q_rsp_if import crl2q_pkg::*;;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [FQ_W-1:0]  found_queue;
  logic             evicted_valid;
  logic [KEY_W-1:0] evicted_key;
  logic [OCC_W-1:0] occupancy;
  modport source(output valid, hit, found_queue, evicted_valid, evicted_key, occupancy,
                 input ready);
  modport sink(input valid, hit, found_queue, evicted_valid, evicted_key, occupancy,
               output ready);
endinterface

// ----- rtl/crl2q_cfg_if.sv -----
// Configuration write channel: register index and data, valid/ready.
// Depends on crl2q_pkg.
interface crl2q_cfg_if import crl2q_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/crl2q_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module crl2q_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/cache_replacement_lru_2q.sv -----
// Channel   Dir  Payload                                                  Transfer when
// cmd       in   operation, key                                           valid & ready
// rsp       out  hit, found_queue, evicted_valid, evicted_key, occupancy  valid & ready
// cfg       in   index, data                                              valid & ready
//
// One command at a time. The key search reads the status RAM one slot per cycle. After
// acceptance, search and dispatch come the list updates in the link RAM (for a hit, a
// remove, or an insert with a 2Q move and an eviction), and then the response is loaded.
// A reclaim can make further A1in moves after the first one.
// After reset a clearing pass invalidates every slot; cmd is held off.
// A waiting response does not block the next command; only the final write into the
// output register waits for rsp.ready.
// Depends on crl2q_pkg, the channel interfaces and crl2q_ram.
module cache_replacement_lru_2q import crl2q_pkg::*; #(
  parameter int ENTRIES   = 64,
  parameter int KEY_WIDTH = 64
) (
  input  logic clk,
  input  logic rst,
  crl2q_cmd_if.sink   cmd,
  crl2q_rsp_if.source rsp,
  crl2q_cfg_if.sink   cfg
);

  localparam int SLOTS = ENTRIES + 1;
  localparam int SW    = $clog2(SLOTS + 1);
  localparam int AW    = $clog2(SLOTS);
  localparam int CMPW  = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;
  localparam int STW   = KEY_WIDTH + 3;
  localparam int LNW   = 2 * SW;
  localparam logic [SW-1:0] NIL = SW'(SLOTS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_DISP,
    S_U0, S_U1, S_U2, S_U3, S_U4,
    S_P0, S_P1, S_DROP,
    S_R0, S_E0, S_M0, S_M1, S_FIN
  } state_t;

  state_t state, ret_u, ret_p;

  // Configuration.
  logic                  policy;
  logic [CFG_DATA_W-1:0] capacity, a1in_lim, a1out_lim;

  // Per-command working registers.
  logic [OP_W-1:0]      op_r;
  logic [KEY_WIDTH-1:0] key_r, stat_key, ek_r;
  logic                 hit_r, ev_r, free_found;
  logic [FQ_W-1:0]      fq_r, qx, tq;
  logic [AW-1:0]        idx;
  logic [SW-1:0]        free_slot, x, pl, nl;

  // Queue bookkeeping, indexed by queue code.
  logic [SW-1:0]    head  [1:3];
  logic [SW-1:0]    tail  [1:3];
  logic [SW-1:0]    qsize [1:3];
  logic [SW-1:0]    resident;
  logic [CNT_W-1:0] hit_cnt, miss_cnt;

  // RAM ports.
  logic           st_we, ln_we;
  logic [AW-1:0]  st_waddr, st_raddr, ln_waddr, ln_raddr;
  logic [STW-1:0] st_wdata, st_rdata;
  logic [LNW-1:0] ln_wdata, ln_rdata;

  logic                 st_valid;
  logic [FQ_W-1:0]      st_queue;
  logic [KEY_WIDTH-1:0] st_key;
  logic [SW-1:0]        ln_next, ln_prev;

  assign st_valid = st_rdata[KEY_WIDTH+2];
  assign st_queue = st_rdata[KEY_WIDTH+1:KEY_WIDTH];
  assign st_key   = st_rdata[KEY_WIDTH-1:0];
  assign ln_next  = ln_rdata[LNW-1:SW];
  assign ln_prev  = ln_rdata[SW-1:0];

  crl2q_ram #(.WIDTH(STW), .DEPTH(SLOTS)) u_status_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  crl2q_ram #(.WIDTH(LNW), .DEPTH(SLOTS)) u_link_ram (
    .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .raddr(ln_raddr), .rdata(ln_rdata)
  );

  // Reclaim decision.
  logic [CMPW-1:0] cap_eff;
  logic            over_cap, rc_evict, rc_move;
  logic [SW-1:0]   rc_slot;
  logic [FQ_W-1:0] rc_queue;
  logic            a1out_over;

  always_comb begin
    cap_eff = (CMPW'(capacity) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : CMPW'(capacity);
    over_cap = CMPW'(resident) > cap_eff;
    rc_evict = 1'b0;
    rc_move  = 1'b0;
    rc_slot  = tail[Q_AM];
    rc_queue = Q_AM;
    if (!policy) begin
      rc_evict = over_cap && (tail[Q_AM] != NIL);
    end else if (!ev_r && over_cap && qsize[Q_A1IN] != '0) begin
      if (CMPW'(qsize[Q_A1IN]) > CMPW'(a1in_lim)) begin
        rc_slot  = tail[Q_A1IN];
        rc_queue = Q_A1IN;
        rc_move  = tail[Q_A1IN] != NIL;
      end else if (qsize[Q_AM] != '0) begin
        rc_evict = tail[Q_AM] != NIL;
      end
    end
    a1out_over = (CMPW'(qsize[Q_A1OUT]) > CMPW'(a1out_lim)) && (tail[Q_A1OUT] != NIL);
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = x[AW-1:0];
    st_wdata = {1'b1, tq, stat_key};
    st_raddr = x[AW-1:0];
    ln_we    = 1'b0;
    ln_waddr = x[AW-1:0];
    ln_wdata = '0;
    ln_raddr = x[AW-1:0];
    case (state)
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = idx;
        st_wdata = '0;
      end
      S_IDLE:   st_raddr = '0;
      S_SEARCH: st_raddr = idx + 1'b1;
      S_U1:     ln_raddr = ln_prev[AW-1:0];
      S_U2: begin
        ln_we    = 1'b1;
        ln_waddr = pl[AW-1:0];
        ln_wdata = {nl, ln_prev};
      end
      S_U3:     ln_raddr = nl[AW-1:0];
      S_U4: begin
        ln_we    = 1'b1;
        ln_waddr = nl[AW-1:0];
        ln_wdata = {ln_next, pl};
      end
      S_P0: begin
        ln_we    = 1'b1;
        ln_wdata = {head[tq], NIL};
        ln_raddr = head[tq][AW-1:0];
        st_we    = 1'b1;
      end
      S_P1: begin
        ln_we    = 1'b1;
        ln_waddr = nl[AW-1:0];
        ln_wdata = {ln_next, x};
      end
      S_DROP: begin
        st_we    = 1'b1;
        st_wdata = '0;
      end
      S_R0:     st_raddr = rc_slot[AW-1:0];
      S_M1:     st_raddr = tail[Q_A1OUT][AW-1:0];
      default: ;
    endcase
  end

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ret_u     <= S_FIN;
      ret_p     <= S_FIN;
      idx       <= '0;
      policy    <= 1'b0;
      capacity  <= CAPACITY_RST;
      a1in_lim  <= A1IN_LIM_RST;
      a1out_lim <= A1OUT_LIM_RST;
      for (int q = 1; q <= 3; q++) begin
        head[q]  <= NIL;
        tail[q]  <= NIL;
        qsize[q] <= '0;
      end
      resident  <= '0;
      hit_cnt   <= '0;
      miss_cnt  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_POLICY:    policy    <= cfg.data[0];
          REG_CAPACITY:  capacity  <= cfg.data;
          REG_A1IN_LIM:  a1in_lim  <= cfg.data;
          REG_A1OUT_LIM: a1out_lim <= cfg.data;
          default: ;
        endcase
      end

      if (state == S_FIN && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == AW'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (cmd.valid) begin
            op_r       <= cmd.operation;
            key_r      <= cmd.key[KEY_WIDTH-1:0];
            hit_r      <= 1'b0;
            fq_r       <= Q_NONE;
            ev_r       <= 1'b0;
            ek_r       <= '0;
            free_found <= 1'b0;
            idx        <= '0;
            state      <= (cmd.operation == OP_RSVD) ? S_FIN : S_SEARCH;
          end
        end

        // Data of slot idx is on the status RAM output this cycle.
        S_SEARCH: begin
          if (st_valid && st_key == key_r) begin
            hit_r    <= 1'b1;
            fq_r     <= st_queue;
            qx       <= st_queue;
            x        <= SW'(idx);
            stat_key <= key_r;
            state    <= S_DISP;
          end else begin
            if (!st_valid && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= SW'(idx);
            end
            if (idx == AW'(SLOTS - 1)) begin
              state <= S_DISP;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        S_DISP: begin
          state <= S_FIN;
          case (op_r)
            OP_LOOKUP, OP_INSERT: begin
              if (hit_r) begin
                hit_cnt <= hit_cnt + 1'b1;
                tq      <= (!policy || qx == Q_A1OUT || qx == Q_NONE) ? Q_AM : qx;
                ret_u   <= S_P0;
                ret_p   <= S_FIN;
                state   <= S_U0;
              end else begin
                miss_cnt <= miss_cnt + 1'b1;
                if (op_r == OP_INSERT && free_found) begin
                  x        <= free_slot;
                  tq       <= policy ? Q_A1IN : Q_AM;
                  stat_key <= key_r;
                  resident <= resident + 1'b1;
                  ret_p    <= S_R0;
                  state    <= S_P0;
                end
              end
            end
            OP_REMOVE: begin
              if (hit_r) begin
                ret_u <= S_DROP;
                state <= S_U0;
              end
            end
            default: ;
          endcase
        end

        // Unlink slot x from queue qx.
        S_U0: state <= S_U1;
        S_U1: begin
          pl <= ln_prev;
          nl <= ln_next;
          if (ln_prev == NIL) begin
            head[qx] <= ln_next;
            state    <= S_U3;
          end else begin
            state <= S_U2;
          end
        end
        S_U2: state <= S_U3;
        S_U3: begin
          if (nl == NIL) begin
            tail[qx] <= pl;
            if (qsize[qx] != '0) qsize[qx] <= qsize[qx] - 1'b1;
            state <= ret_u;
          end else begin
            state <= S_U4;
          end
        end
        S_U4: begin
          if (qsize[qx] != '0) qsize[qx] <= qsize[qx] - 1'b1;
          state <= ret_u;
        end

        // Push slot x on the head of queue tq; the status word is written here too.
        S_P0: begin
          head[tq]  <= x;
          qsize[tq] <= qsize[tq] + 1'b1;
          if (head[tq] == NIL) begin
            tail[tq] <= x;
            state    <= ret_p;
          end else begin
            nl    <= head[tq];
            state <= S_P1;
          end
        end
        S_P1: state <= ret_p;

        S_DROP: begin
          if (resident != '0) resident <= resident - 1'b1;
          state <= S_FIN;
        end

        S_R0: begin
          x  <= rc_slot;
          qx <= rc_queue;
          if (rc_evict) begin
            state <= S_E0;
          end else if (rc_move) begin
            state <= S_M0;
          end else begin
            state <= S_FIN;
          end
        end

        S_E0: begin
          ev_r  <= 1'b1;
          ek_r  <= st_key;
          ret_u <= S_DROP;
          state <= S_U0;
        end

        // A1in tail moves to the A1out head.
        S_M0: begin
          stat_key <= st_key;
          tq       <= Q_A1OUT;
          ret_u    <= S_P0;
          ret_p    <= S_M1;
          state    <= S_U0;
        end

        S_M1: begin
          if (a1out_over) begin
            x     <= tail[Q_A1OUT];
            qx    <= Q_A1OUT;
            state <= S_E0;
          end else begin
            state <= S_R0;
          end
        end

        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.hit           <= hit_r;
            rsp.found_queue   <= fq_r;
            rsp.evicted_valid <= ev_r;
            rsp.evicted_key   <= ev_r ? KEY_W'(ek_r) : '0;
            rsp.occupancy     <= OCC_W'(resident);
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/crl2q_checker.sv -----
// Port-level checks for cache_replacement_lru_2q, attached by bind.
// Depends on crl2q_pkg and the top level's channel interfaces.
module crl2q_checker import crl2q_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic             hit,
  input logic [FQ_W-1:0]  found_queue,
  input logic             evicted_valid,
  input logic [KEY_W-1:0] evicted_key,
  input logic [OCC_W-1:0] occupancy
);

  // Only one command is in work at a time.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while another is in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(evicted_key) && $stable(occupancy))
    else $error("stalled response changed");

  a_hit_queue: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (hit == (found_queue != Q_NONE)))
    else $error("hit and found queue disagree");

  a_no_ev_key: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !evicted_valid |-> evicted_key == '0)
    else $error("evicted key nonzero without eviction");

  // Only an insert of a new key can cause an eviction.
  a_ev_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && evicted_valid |-> !hit)
    else $error("eviction on a hit");

endmodule

bind cache_replacement_lru_2q crl2q_checker u_crl2q_checker (
  .clk(clk),
  .rst(rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .hit(rsp.hit),
  .found_queue(rsp.found_queue),
  .evicted_valid(rsp.evicted_valid),
  .evicted_key(rsp.evicted_key),
  .occupancy(rsp.occupancy)
);

// ----- dv/tb_cache_replacement_lru_2q.sv -----
// Self-checking testbench for the LRU / 2Q cache directory: random and directed
// lookup, insert and remove traffic checked against a behavioral directory model.
// Depends on crl2q_pkg, the channel interfaces and the cache_replacement_lru_2q RTL.
module tb_cache_replacement_lru_2q import crl2q_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 65;
  localparam int NIL   = NSLOT;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [FQ_W-1:0]  found_queue;
    logic             evicted_valid;
    logic [KEY_W-1:0] evicted_key;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crl2q_cmd_if cmd_ch();
  crl2q_rsp_if rsp_ch();
  crl2q_cfg_if cfg_ch();

  cache_replacement_lru_2q dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
  );

  // Directory model state.
  logic [KEY_W-1:0] m_key [NSLOT];
  bit               m_valid [NSLOT];
  int               m_queue [NSLOT];
  int               m_next [NSLOT];
  int               m_prev [NSLOT];
  int               m_head [3];
  int               m_tail [3];
  int               m_size [3];
  int               m_resident;
  int               m_policy, m_capacity, m_a1in_lim, m_a1out_lim;

  cmd_t pending_cmds [$];
  rsp_t expected_rsps [$];
  logic [KEY_W-1:0] key_pool [$];
  int   errors = 0;
  int   n_cmds = 0, n_rsps = 0, n_hits = 0, n_evicts = 0;
  bit   hold_cmds = 1'b0;
  int   cmd_gap = 0, rsp_gap = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void list_unlink(int s);
    int q;
    q = m_queue[s];
    if (q < 1 || q > 3) return;
    if (m_prev[s] >= NSLOT) m_head[q-1] = m_next[s];
    else m_next[m_prev[s]] = m_next[s];
    if (m_next[s] >= NSLOT) m_tail[q-1] = m_prev[s];
    else m_prev[m_next[s]] = m_prev[s];
    if (m_size[q-1] > 0) m_size[q-1]--;
    m_queue[s] = 0;
  endfunction

  function automatic void list_push(int s, int q);
    int n;
    n = m_head[q-1];
    m_prev[s] = NIL;
    m_next[s] = n;
    if (n >= NSLOT) m_tail[q-1] = s;
    else m_prev[n] = s;
    m_head[q-1] = s;
    m_size[q-1]++;
    m_queue[s] = q;
  endfunction

  function automatic void drop_entry(int s);
    list_unlink(s);
    m_valid[s] = 1'b0;
    if (m_resident > 0) m_resident--;
  endfunction

  function automatic void evict_entry(int s, inout rsp_t r);
    r.evicted_valid = 1'b1;
    r.evicted_key   = m_key[s];
    drop_entry(s);
  endfunction

  function automatic void reclaim_entries(inout rsp_t r);
    int lim, t;
    lim = (m_capacity > 64) ? 64 : m_capacity;
    if (m_policy == 0) begin
      t = m_tail[0];
      if (m_resident > lim && t < NSLOT) evict_entry(t, r);
      return;
    end
    while (!r.evicted_valid && m_resident > lim && m_size[1] > 0) begin
      if (m_size[1] > m_a1in_lim) begin
        t = m_tail[1];
        if (t >= NSLOT) break;
        list_unlink(t);
        list_push(t, 3);
        if (m_size[2] > m_a1out_lim) begin
          t = m_tail[2];
          if (t < NSLOT) evict_entry(t, r);
        end
      end else if (m_size[0] > 0) begin
        t = m_tail[0];
        if (t >= NSLOT) break;
        evict_entry(t, r);
      end else begin
        break;
      end
    end
  endfunction

  function automatic void promote_entry(int s);
    int q, target;
    q = m_queue[s];
    target = (m_policy == 0 || q == 3 || q < 1) ? 1 : q;
    list_unlink(s);
    list_push(s, target);
  endfunction

  function automatic rsp_t directory_access(cmd_t c);
    rsp_t r;
    int   s, f;
    r = '0;
    s = NIL;
    for (int i = 0; i < NSLOT; i++)
      if (s == NIL && m_valid[i] && m_key[i] == c.key) s = i;
    if (c.operation == OP_RSVD) begin
      r.occupancy = m_resident[OCC_W-1:0];
      return r;
    end
    r.hit = (s < NSLOT);
    r.found_queue = r.hit ? m_queue[s][FQ_W-1:0] : Q_NONE;
    case (c.operation)
      OP_LOOKUP: if (r.hit) promote_entry(s);
      OP_INSERT: begin
        if (r.hit) begin
          promote_entry(s);
        end else begin
          f = NIL;
          for (int i = 0; i < NSLOT; i++)
            if (f == NIL && !m_valid[i]) f = i;
          if (f < NSLOT) begin
            m_valid[f] = 1'b1;
            m_key[f] = c.key;
            list_push(f, m_policy ? 2 : 1);
            m_resident++;
            reclaim_entries(r);
          end
        end
      end
      OP_REMOVE: if (r.hit) drop_entry(s);
      default: ;
    endcase
    r.occupancy = m_resident[OCC_W-1:0];
    return r;
  endfunction

  // Command driver.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_gap <= 0;
    end else if (cmd_ch.valid && !cmd_ch.ready) begin
      // hold the current transfer
    end else if (cmd_gap > 0) begin
      cmd_ch.valid <= 1'b0;
      cmd_gap <= cmd_gap - 1;
    end else if (pending_cmds.size() > 0 && !hold_cmds) begin
      cmd_t c;
      c = pending_cmds.pop_front();
      expected_rsps.push_back(directory_access(c));
      cmd_ch.valid <= 1'b1;
      cmd_ch.operation <= c.operation;
      cmd_ch.key <= c.key;
      n_cmds++;
      cmd_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    end else begin
      cmd_ch.valid <= 1'b0;
    end
  end

  // Response monitor and ready generator.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_gap <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        int g;
        n_rsps++;
        if (expected_rsps.size() == 0) begin
          $error("unexpected response, occupancy %0d", rsp_ch.occupancy);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_ch.hit !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, rsp_ch.hit); errors++;
          end
          if (rsp_ch.found_queue !== e.found_queue) begin
            $error("found_queue: expected %0d actual %0d", e.found_queue,
                   rsp_ch.found_queue); errors++;
          end
          if (rsp_ch.evicted_valid !== e.evicted_valid) begin
            $error("evicted_valid: expected %0d actual %0d", e.evicted_valid,
                   rsp_ch.evicted_valid); errors++;
          end
          if (rsp_ch.evicted_key !== e.evicted_key) begin
            $error("evicted_key: expected %h actual %h", e.evicted_key,
                   rsp_ch.evicted_key); errors++;
          end
          if (rsp_ch.occupancy !== e.occupancy) begin
            $error("occupancy: expected %0d actual %0d", e.occupancy,
                   rsp_ch.occupancy); errors++;
          end
          n_hits += e.hit;
          n_evicts += e.evicted_valid;
        end
        g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        rsp_gap <= g;
        rsp_ch.ready <= (g == 0);
      end else if (rsp_gap > 0) begin
        rsp_gap <= rsp_gap - 1;
        rsp_ch.ready <= (rsp_gap == 1);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_POLICY:    m_policy = value & 1;
      REG_CAPACITY:  m_capacity = value;
      REG_A1IN_LIM:  m_a1in_lim = value;
      REG_A1OUT_LIM: m_a1out_lim = value;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || cmd_ch.valid)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    k = {$urandom, $urandom};
    key_pool.push_back(k);
    return k;
  endfunction

  function automatic void queue_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
    cmd_t c;
    c.operation = op;
    c.key = k;
    pending_cmds.push_back(c);
  endfunction

  task automatic random_phase(int count, int pool_size);
    int r;
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool.push_back({$urandom, $urandom});
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (r < 9) queue_cmd(OP_INSERT, pick_key());
      else if (r < 16) queue_cmd(OP_LOOKUP, pick_key());
      else if (r < 19) queue_cmd(OP_REMOVE, pick_key());
      else queue_cmd(OP_RSVD, pick_key());
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      m_valid[i] = 1'b0; m_queue[i] = 0; m_next[i] = NIL; m_prev[i] = NIL; m_key[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      m_head[i] = NIL; m_tail[i] = NIL; m_size[i] = 0;
    end
    m_resident = 0;
    m_policy = 0;
    m_capacity = CAPACITY_RST;
    m_a1in_lim = A1IN_LIM_RST;
    m_a1out_lim = A1OUT_LIM_RST;
    cmd_ch.valid = 1'b0; cmd_ch.operation = OP_LOOKUP; cmd_ch.key = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_POLICY; cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: key extremes, all operations, misses, hits and the unused code.
    queue_cmd(OP_LOOKUP, '0);
    queue_cmd(OP_INSERT, '0);
    queue_cmd(OP_INSERT, '1);
    queue_cmd(OP_INSERT, 64'h5555_5555_5555_5555);
    queue_cmd(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_cmd(OP_INSERT, '1);
    queue_cmd(OP_LOOKUP, '0);
    queue_cmd(OP_RSVD, '1);
    queue_cmd(OP_REMOVE, 64'h5555_5555_5555_5555);
    queue_cmd(OP_REMOVE, 64'h5555_5555_5555_5555);
    queue_cmd(OP_LOOKUP, 64'h5555_5555_5555_5555);
    wait_drained();

    // LRU with capacity 1: every new insert evicts.
    write_reg(REG_CAPACITY, 1);
    for (int i = 0; i < 6; i++) queue_cmd(OP_INSERT, 64'h100 + i);
    wait_drained();

    // Fill the store past ENTRIES with a capacity above ENTRIES, so inserts evict at the clamped limit.
    write_reg(REG_CAPACITY, 127);
    for (int i = 0; i < 70; i++) queue_cmd(OP_INSERT, {$urandom, $urandom});
    wait_drained();
    // Switch to 2Q while the store is full of queue 1 entries: reclaim with 2Q.
    write_reg(REG_POLICY, 1);
    write_reg(REG_A1IN_LIM, 0);
    write_reg(REG_A1OUT_LIM, 0);
    write_reg(REG_CAPACITY, 64);
    random_phase(40, 80);

    write_reg(REG_A1IN_LIM, 64);
    write_reg(REG_A1OUT_LIM, 64);
    write_reg(REG_CAPACITY, 8);
    random_phase(60, 16);

    write_reg(REG_A1IN_LIM, 2);
    write_reg(REG_A1OUT_LIM, 3);
    write_reg(REG_CAPACITY, 6);
    random_phase(50, 12);
    // Let the response side fully catch up before sending more.
    hold_cmds = 1'b1;
    random_phase(0, 1);
    hold_cmds = 1'b0;
    random_phase(50, 12);

    // Back to LRU with leftovers sitting in A1in and A1out.
    write_reg(REG_POLICY, 0);
    write_reg(REG_CAPACITY, 5);
    random_phase(60, 10);

    write_reg(REG_POLICY, 1);
    write_reg(REG_A1IN_LIM, 1);
    write_reg(REG_A1OUT_LIM, 32);
    write_reg(REG_CAPACITY, 20);
    random_phase(90, 40);

    write_reg(REG_POLICY, 0);
    write_reg(REG_CAPACITY, 64);
    random_phase(60, 100);

    $display("Covered %0d commands, %0d responses, %0d hits and %0d evictions", n_cmds,
             n_rsps, n_hits, n_evicts);
    $display("across LRU and 2Q with capacities from 1 to 127 and queue limits 0 to 64.");
    if (errors == 0) $display("cache_replacement_lru_2q test passed");
    else $display("cache_replacement_lru_2q test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("cache_replacement_lru_2q test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/crl2q_pkg.sv
rtl/crl2q_cmd_if.sv
rtl/crl2q_rsp_if.sv
rtl/crl2q_cfg_if.sv
rtl/crl2q_ram.sv
rtl/cache_replacement_lru_2q.sv
rtl/crl2q_checker.sv
dv/tb_cache_replacement_lru_2q.sv
